// ===== rtl/core/gtg_pkg.sv =====
// Shared types and constants for the go-to-goal heading controller.
`timescale 1ns / 1ps
package gtg_pkg;

  localparam int unsigned CW = 40;   // CORDIC datapath width
  localparam logic [31:0] KINV_Q30 = 32'd652032874;
  localparam logic [30:0] PI_Q29   = 31'd1686629713;

  typedef enum logic [2:0] {
    REG_MAX_LIN   = 3'd0,
    REG_MAX_ANG   = 3'd1,
    REG_GAIN      = 3'd2,
    REG_ALIGN     = 3'd3,
    REG_TOL       = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } cord_ctl_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0:  r = 32'h20000000;
        5'd1:  r = 32'h12E4051E;
        5'd2:  r = 32'h09FB385B;
        5'd3:  r = 32'h051111D4;
        5'd4:  r = 32'h028B0D43;
        5'd5:  r = 32'h0145D7E1;
        5'd6:  r = 32'h00A2F61E;
        5'd7:  r = 32'h00517C55;
        5'd8:  r = 32'h0028BE53;
        5'd9:  r = 32'h00145F2F;
        5'd10: r = 32'h000A2F98;
        5'd11: r = 32'h000517CC;
        5'd12: r = 32'h00028BE6;
        5'd13: r = 32'h000145F3;
        5'd14: r = 32'h0000A2F9;
        5'd15: r = 32'h0000517C;
        5'd16: r = 32'h000028BE;
        5'd17: r = 32'h0000145F;
        5'd18: r = 32'h00000A2F;
        5'd19: r = 32'h00000517;
        5'd20: r = 32'h0000028B;
        5'd21: r = 32'h00000145;
        5'd22: r = 32'h000000A2;
        5'd23: r = 32'h00000051;
        default: r = 32'h0;
      endcase
      return r;
    end
  endfunction

endpackage

// ===== rtl/core/gtg_cordic.sv =====
// Iterative vectoring CORDIC: one micro-rotation per cycle.
`timescale 1ns / 1ps
module gtg_cordic import gtg_pkg::*; #(
  parameter int unsigned STEPS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  output logic                 done,
  output logic [CW-1:0]        mag_raw,
  output logic [31:0]          angle
);
  localparam int unsigned IW = $clog2(STEPS + 1);

  logic signed [CW-1:0] x_r, y_r;
  logic [31:0]          z_r;
  logic [IW-1:0]        i_r;
  logic                 busy_r, done_r;
  logic signed [CW-1:0] xs, ys;
  logic [31:0]          at;

  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;
  assign at = atan_entry(5'(i_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        i_r    <= '0;
        if (x_in < 0) begin
          x_r <= -x_in;
          y_r <= -y_in;
          z_r <= 32'h80000000;
        end else begin
          x_r <= x_in;
          y_r <= y_in;
          z_r <= '0;
        end
      end else if (busy_r) begin
        if (y_r > 0) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + at;
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - at;
        end
        i_r <= i_r + 1'b1;
        if (i_r == IW'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done    = done_r;
  assign mag_raw = x_r;
  assign angle   = z_r;

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("cordic done while busy");
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> i_r < IW'(STEPS)) else $error("cordic step out of range");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("done held");
endmodule

// ===== rtl/core/gtg_divider.sv =====
// Restoring divider, one quotient bit per cycle, 50-bit dividend.
`timescale 1ns / 1ps
module gtg_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [49:0] dividend,
  input  logic [30:0] divisor,
  output logic        done,
  output logic [49:0] quotient
);
  logic [49:0] q_r;
  logic [31:0] rem_r;
  logic [5:0]  n_r;
  logic        busy_r, done_r;
  logic [31:0] sh;
  logic [32:0] diff;

  assign sh   = {rem_r[30:0], q_r[49]};
  assign diff = {1'b0, sh} - {2'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      n_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        q_r    <= dividend;
        rem_r  <= '0;
        n_r    <= '0;
      end else if (busy_r) begin
        if (!diff[32]) begin
          rem_r <= diff[31:0];
          q_r   <= {q_r[48:0], 1'b1};
        end else begin
          rem_r <= sh;
          q_r   <= {q_r[48:0], 1'b0};
        end
        n_r <= n_r + 1'b1;
        if (n_r == 6'd49) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("div done held");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("div done while busy");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> n_r < 6'd50) else $error("div count out of range");
endmodule

// ===== rtl/core/go_to_goal_heading_controller_top.sv =====
// Top level of the go-to-goal heading controller.
//
// Input requests (in_valid/in_ready) carry pose, goal, elapsed time and goal_start.
// One result request per input leaves on out_valid/out_ready.
// Registers are written on the cfg_ channel (index 0..4); the user is to write them
// only while the block is idle, which the block itself does not enforce. Sequence
// per request: CORDIC on the step since the last pose, CORDIC on the vector to
// the goal, then the bit-serial remaining-time division (skipped when the linear
// limit is zero), which forms its 50 quotient bits one at a time overlapped with
// the gain multiply and clamps. The shared CORDIC and the bit-serial divider
// bound how often a request can be taken.
// in_ready is high only in the idle state. The result sits in an output
// register; while the receiver stalls it holds, and the next request is
// taken only once the result has gone.
// Reset (rst_n low, synchronous) loads register defaults and clears the
// previous pose and the odometer and time totals.
`timescale 1ns / 1ps
module go_to_goal_heading_controller_top import gtg_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_pose_x,
  input  logic signed [31:0] in_pose_y,
  input  logic signed [15:0] in_pose_heading,
  input  logic signed [31:0] in_target_x,
  input  logic signed [31:0] in_target_y,
  input  logic [19:0]        in_elapsed_us,
  input  logic               in_goal_start,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_turn_rate,
  output logic [30:0]        out_drive_speed,
  output logic               out_reached,
  output logic [31:0]        out_remaining_distance,
  output logic [31:0]        out_remaining_time,
  output logic [47:0]        out_odometer,
  output logic [47:0]        out_motion_time_us,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_STEP, S_STEP_MUL, S_STEP_ACC, S_GOAL, S_GOAL_MUL, S_SCALE,
    S_MUL1, S_MUL2, S_WAIT_DIV, S_OUT
  } state_t;

  state_t state_r;

  logic [30:0] max_lin_r, tol_r;
  logic [14:0] max_ang_r, gain_r, align_r;
  logic signed [31:0] prev_x_r, prev_y_r, px_r, py_r, tx_r, ty_r;
  logic signed [15:0] hd_r;
  logic [19:0] el_r;
  logic [47:0] dist_tot_r, time_tot_r;

  // CORDIC operands and control
  logic cstart;
  logic signed [CW-1:0] cx, cy;
  logic cdone;
  logic [CW-1:0] cmag;
  logic [31:0]   cang;

  // one shared 32x32 multiplier
  logic [31:0] ma, mb;
  logic [63:0] mp;
  logic [63:0] prod_r;
  logic [47:0] dist_r;
  logic [31:0] z_r;
  logic signed [15:0] err_r;
  logic [15:0] mag_err_r;
  logic [30:0] gm_r;

  logic dstart, ddone;
  logic [49:0] dq;
  logic [31:0] rtime_r;

  logic signed [15:0] turn_r;
  logic [30:0] drive_r;
  logic reached_r, ovalid_r;
  logic [31:0] rdist_r;

  assign mp = ma * mb;

  always_comb begin
    ma = 32'(cmag);
    mb = KINV_Q30;
    cx = CW'(px_r) - CW'(prev_x_r);
    cy = CW'(py_r) - CW'(prev_y_r);
    cstart = 1'b0;
    dstart = 1'b0;
    unique case (state_r)
      S_STEP_MUL, S_GOAL_MUL: begin
        ma = 32'(cmag);
        mb = KINV_Q30;
      end
      S_MUL1: begin
        ma = {17'd0, gain_r};
        mb = {16'd0, mag_err_r};
      end
      S_MUL2: begin
        ma = {1'b0, gm_r};
        mb = {1'b0, PI_Q29};
      end
      S_STEP_ACC: begin
        cx = CW'(tx_r) - CW'(px_r);
        cy = CW'(ty_r) - CW'(py_r);
        cstart = 1'b1;
      end
      S_SCALE: dstart = (max_lin_r != '0);
      default: ;
    endcase
    if (state_r == S_IDLE) begin
      cx = CW'(signed'(in_pose_x)) - (in_goal_start ? CW'(signed'(in_pose_x))
                                                     : CW'(prev_x_r));
      cy = CW'(signed'(in_pose_y)) - (in_goal_start ? CW'(signed'(in_pose_y))
                                                     : CW'(prev_y_r));
      cstart = in_valid;
    end
  end

  gtg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk, .rst_n, .start(cstart), .x_in(cx), .y_in(cy),
    .done(cdone), .mag_raw(cmag), .angle(cang)
  );

  gtg_divider u_div (
    .clk, .rst_n, .start(dstart), .dividend({dist_r[33:0], 16'd0}),
    .divisor(max_lin_r), .done(ddone), .quotient(dq)
  );

  // magnitude fits in 34 bits: the low 32 go through the shared multiplier,
  // the high 8 bits (CW-1:32) through a narrow one
  logic [47:0] scaled;
  logic [39:0] hip;
  logic [CW+31:0] fullp;
  assign hip    = 40'(cmag[CW-1:32]) * 40'(KINV_Q30);
  assign fullp  = {hip, 32'd0} + 72'(mp);
  assign scaled = 48'((fullp + 72'(1 << 29)) >> 30);

  logic [48:0] dsum;
  logic [48:0] tsum;
  assign dsum = {1'b0, dist_tot_r} + {1'b0, dist_r};
  assign tsum = {1'b0, time_tot_r} + 49'(el_r);

  logic [15:0] bearing, errw;
  assign bearing = 16'((33'(z_r) + 33'h8000) >> 16);
  assign errw    = bearing - hd_r;

  logic [31:0] prodr;
  assign prodr = 32'((prod_r + 64'(1) * 64'h0000_0800_0000_0000) >> 44);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      max_lin_r  <= 31'd131072;
      max_ang_r  <= 15'd4096;
      gain_r     <= 15'd6144;
      align_r    <= 15'd3129;
      tol_r      <= 31'd32768;
      prev_x_r   <= '0;
      prev_y_r   <= '0;
      dist_tot_r <= '0;
      time_tot_r <= '0;
      ovalid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MAX_LIN: max_lin_r <= cfg_data[30:0];
          REG_MAX_ANG: max_ang_r <= cfg_data[14:0];
          REG_GAIN:    gain_r    <= cfg_data[14:0];
          REG_ALIGN:   align_r   <= cfg_data[14:0];
          REG_TOL:     tol_r     <= cfg_data[30:0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          px_r <= in_pose_x;
          py_r <= in_pose_y;
          hd_r <= in_pose_heading;
          tx_r <= in_target_x;
          ty_r <= in_target_y;
          el_r <= in_elapsed_us;
          state_r <= S_STEP;
        end
        S_STEP: if (cdone) state_r <= S_STEP_MUL;
        S_STEP_MUL: begin
          dist_r  <= scaled;
          state_r <= S_STEP_ACC;
        end
        S_STEP_ACC: begin
          dist_tot_r <= dsum[48] ? '1 : dsum[47:0];
          time_tot_r <= tsum[48] ? '1 : tsum[47:0];
          prev_x_r   <= px_r;
          prev_y_r   <= py_r;
          state_r    <= S_GOAL;
        end
        S_GOAL: if (cdone) state_r <= S_GOAL_MUL;
        S_GOAL_MUL: begin
          dist_r  <= scaled;
          z_r     <= cang;
          state_r <= S_SCALE;
        end
        S_SCALE: begin
          err_r     <= signed'(errw);
          mag_err_r <= errw[15] ? 16'(-errw) : errw;
          rdist_r   <= (dist_r[47:32] != '0) ? '1 : dist_r[31:0];
          reached_r <= dist_r <= 48'(tol_r);
          state_r   <= S_MUL1;
        end
        S_MUL1: begin
          gm_r    <= 31'(mp);
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          prod_r  <= mp;
          state_r <= S_WAIT_DIV;
        end
        S_WAIT_DIV: if (ddone || max_lin_r == '0) begin
          if (max_lin_r == '0 || dq[49:32] != '0) rtime_r <= '1;
          else rtime_r <= dq[31:0];
          if (reached_r) begin
            turn_r  <= '0;
            drive_r <= '0;
          end else begin
            if (prodr > 32'(max_ang_r))
              turn_r <= err_r[15] ? -16'(max_ang_r) : 16'(max_ang_r);
            else
              turn_r <= err_r[15] ? -16'(prodr) : 16'(prodr);
            if (mag_err_r < 16'(align_r))
              drive_r <= (dist_r < 48'(max_lin_r)) ? 31'(dist_r) : max_lin_r;
            else
              drive_r <= '0;
          end
          ovalid_r <= 1'b1;
          state_r  <= S_OUT;
        end
        S_OUT: if (out_ready) begin
          ovalid_r <= 1'b0;
          state_r  <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = ovalid_r;
  assign out_turn_rate          = turn_r;
  assign out_drive_speed        = drive_r;
  assign out_reached            = reached_r;
  assign out_remaining_distance = rdist_r;
  assign out_remaining_time     = rtime_r;
  assign out_odometer           = dist_tot_r;
  assign out_motion_time_us     = time_tot_r;

  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_OUT) else $error("result outside output state");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("ready while result pending");
  a_reach_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_reached) |-> (out_turn_rate == 0 && out_drive_speed == 0))
    else $error("command non-zero at goal");
endmodule

// ===== verif/gtg_checker.sv =====
// Checker for the go-to-goal controller: watches all channels, predicts and compares results.
`timescale 1ns / 1ps
module gtg_checker import gtg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] in_pose_x,
  input  logic signed [31:0] in_pose_y,
  input  logic signed [15:0] in_pose_heading,
  input  logic signed [31:0] in_target_x,
  input  logic signed [31:0] in_target_y,
  input  logic [19:0]        in_elapsed_us,
  input  logic               in_goal_start,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] out_turn_rate,
  input  logic [30:0]        out_drive_speed,
  input  logic               out_reached,
  input  logic [31:0]        out_remaining_distance,
  input  logic [31:0]        out_remaining_time,
  input  logic [47:0]        out_odometer,
  input  logic [47:0]        out_motion_time_us,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);

  localparam int unsigned STEPS = 16;
  localparam logic [63:0] SAT48 = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] SAT32 = 64'hFFFF_FFFF;
  localparam logic [31:0] ARCTAN [0:23] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  typedef struct {
    logic signed [15:0] turn_rate;
    logic [30:0]        drive_speed;
    logic               reached;
    logic [31:0]        remaining_distance;
    logic [31:0]        remaining_time;
    logic [47:0]        odometer;
    logic [47:0]        motion_time_us;
  } command_t;

  command_t    cmd_q[$];
  logic [63:0] lin_lim, ang_lim, gain, align_thr, tol;
  logic [31:0] last_x, last_y;
  logic [63:0] odo_total, run_time;

  // vectoring rotation: gain-corrected magnitude plus 32-bit binary angle
  function automatic logic [63:0] vector_mag(input longint vx, input longint vy,
                                             output logic [31:0] angle);
    longint      x, y, xs, ys;
    logic [31:0] z;
    logic [63:0] m;
    x = vx;
    y = vy;
    z = 32'h0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ARCTAN[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ARCTAN[i];
      end
    end
    angle = z;
    m = 64'(x) * 64'd652032874 + (64'd1 << 29);
    return m >> 30;
  endfunction

  function automatic command_t steer_to_goal();
    command_t    c;
    longint      px, py, lx, ly;
    logic [31:0] z, dummy;
    logic [63:0] stepd, goal_dist, prod, mag, bear;
    logic [15:0] e16;
    logic signed [15:0] err;
    px = longint'(in_pose_x);
    py = longint'(in_pose_y);
    lx = in_goal_start ? px : longint'($signed(last_x));
    ly = in_goal_start ? py : longint'($signed(last_y));
    stepd = vector_mag(px - lx, py - ly, dummy);
    odo_total = odo_total + stepd;
    if (odo_total > SAT48) odo_total = SAT48;
    run_time = run_time + 64'(in_elapsed_us);
    if (run_time > SAT48) run_time = SAT48;
    last_x = in_pose_x;
    last_y = in_pose_y;

    goal_dist = vector_mag(longint'(in_target_x) - px, longint'(in_target_y) - py, z);
    c.remaining_distance = (goal_dist > SAT32) ? 32'hFFFF_FFFF : goal_dist[31:0];
    if (lin_lim == 0) begin
      c.remaining_time = 32'hFFFF_FFFF;
    end else begin
      prod = (goal_dist << 16) / lin_lim;
      c.remaining_time = (prod > SAT32) ? 32'hFFFF_FFFF : prod[31:0];
    end
    c.reached = (goal_dist <= tol);
    c.turn_rate = '0;
    c.drive_speed = '0;
    if (!c.reached) begin
      bear = (64'(z) + 64'h8000) >> 16;
      e16 = bear[15:0] - in_pose_heading;
      err = $signed(e16);
      mag = (err < 0) ? 64'(-longint'(err)) : 64'(err);
      prod = (gain * mag * 64'd1686629713 + (64'd1 << 43)) >> 44;
      if (prod > ang_lim) prod = ang_lim;
      c.turn_rate = (err < 0) ? -$signed(prod[15:0]) : $signed(prod[15:0]);
      if (mag < align_thr)
        c.drive_speed = (goal_dist < lin_lim) ? goal_dist[30:0] : lin_lim[30:0];
    end
    c.odometer = odo_total[47:0];
    c.motion_time_us = run_time[47:0];
    return c;
  endfunction

  always @(posedge clk) begin
    command_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      lin_lim <= 64'd131072;
      ang_lim <= 64'd4096;
      gain <= 64'd6144;
      align_thr <= 64'd3129;
      tol <= 64'd32768;
      last_x = '0;
      last_y = '0;
      odo_total = '0;
      run_time = '0;
      cmd_q.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_MAX_LIN: lin_lim <= 64'(cfg_data[30:0]);
          REG_MAX_ANG: ang_lim <= 64'(cfg_data[14:0]);
          REG_GAIN:    gain <= 64'(cfg_data[14:0]);
          REG_ALIGN:   align_thr <= 64'(cfg_data[14:0]);
          REG_TOL:     tol <= 64'(cfg_data[30:0]);
          default: ;
        endcase
      end
      if (in_valid && in_ready) cmd_q = {cmd_q, steer_to_goal()};
      if (out_valid && out_ready) begin
        if (cmd_q.size() == 0) begin
          $error("result with nothing expected");
          errs++;
        end else begin
          want = cmd_q.pop_front();
          if (out_turn_rate !== want.turn_rate) begin
            $error("turn_rate exp %0d got %0d", want.turn_rate, out_turn_rate);
            errs++;
          end
          if (out_drive_speed !== want.drive_speed) begin
            $error("drive_speed exp %0d got %0d", want.drive_speed, out_drive_speed);
            errs++;
          end
          if (out_reached !== want.reached) begin
            $error("reached exp %0d got %0d", want.reached, out_reached);
            errs++;
          end
          if (out_remaining_distance !== want.remaining_distance) begin
            $error("remaining_distance exp %0d got %0d", want.remaining_distance,
                   out_remaining_distance);
            errs++;
          end
          if (out_remaining_time !== want.remaining_time) begin
            $error("remaining_time exp %0d got %0d", want.remaining_time, out_remaining_time);
            errs++;
          end
          if (out_odometer !== want.odometer) begin
            $error("odometer exp %0d got %0d", want.odometer, out_odometer);
            errs++;
          end
          if (out_motion_time_us !== want.motion_time_us) begin
            $error("motion_time_us exp %0d got %0d", want.motion_time_us, out_motion_time_us);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending <= cmd_q.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the go-to-goal controller: stimulus, receiver and verdict.
`timescale 1ns / 1ps
module tb_top;
  import gtg_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_TICKS = 1530;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_pose_x = '0;
  logic signed [31:0] in_pose_y = '0;
  logic signed [15:0] in_pose_heading = '0;
  logic signed [31:0] in_target_x = '0;
  logic signed [31:0] in_target_y = '0;
  logic [19:0]        in_elapsed_us = '0;
  logic               in_goal_start = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_turn_rate;
  logic [30:0]        out_drive_speed;
  logic               out_reached;
  logic [31:0]        out_remaining_distance;
  logic [31:0]        out_remaining_time;
  logic [47:0]        out_odometer;
  logic [47:0]        out_motion_time_us;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  int fail_count;
  int pending;
  int cycles = 0;
  // handshake flags captured at the rising edge, read at the falling edge
  logic in_took = 1'b0, out_took = 1'b0, cfg_took = 1'b0;
  // ask the receiver for one long hold-off
  logic hold_off_req = 1'b0;
  logic no_gaps = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  go_to_goal_heading_controller_top u_dut (.*);

  gtg_checker u_chk (.*);

  always @(posedge clk) begin
    in_took <= in_valid && in_ready;
    out_took <= out_valid && out_ready;
    cfg_took <= cfg_valid && cfg_ready;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Receiver: random stall per request, or a long hold-off when asked.
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready = 1'b0;
        for (int i = 0; i < 600; i++) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        if (stall > 0) begin
          out_ready = 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      out_ready = 1'b1;
      do @(negedge clk); while (!out_took);
    end
  end

  // Offer one control tick; valid stays high on return.
  task automatic send_tick(input logic signed [31:0] px, input logic signed [31:0] py,
                           input logic signed [15:0] hd, input logic signed [31:0] tx,
                           input logic signed [31:0] ty, input logic [19:0] el,
                           input logic gs);
    int gap;
    gap = no_gaps ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14));
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_pose_x = px;
    in_pose_y = py;
    in_pose_heading = hd;
    in_target_x = tx;
    in_target_y = ty;
    in_elapsed_us = el;
    in_goal_start = gs;
    in_valid = 1'b1;
    do @(negedge clk); while (!in_took);
  endtask

  // Register writes only once every request has drained.
  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    cfg_index = idx;
    cfg_data = value;
    cfg_valid = 1'b1;
    do @(negedge clk); while (!cfg_took);
    cfg_valid = 1'b0;
  endtask

  task automatic load_settings(input logic [31:0] lin, input logic [31:0] ang,
                               input logic [31:0] g, input logic [31:0] al,
                               input logic [31:0] tl);
    wait_idle();
    write_reg(REG_MAX_LIN, lin);
    write_reg(REG_MAX_ANG, ang);
    write_reg(REG_GAIN, g);
    write_reg(REG_ALIGN, al);
    write_reg(REG_TOL, tl);
  endtask

  // One random tick: mostly a goal approach along an axis with a roughly
  // matching heading, sometimes full-range noise.
  logic signed [31:0] cur_x, cur_y, goal_x, goal_y;
  logic signed [15:0] axis_hd;

  task automatic random_tick(input bit fresh);
    logic [19:0] el;
    el = ($urandom_range(0, 9) == 0) ? 20'($urandom) : 20'($urandom_range(0, 20000));
    if ($urandom_range(0, 4) == 0) begin
      send_tick($urandom, $urandom, 16'($urandom), $urandom, $urandom, 20'($urandom),
                1'($urandom));
    end else begin
      if (fresh) begin
        cur_x = $signed(32'($urandom)) >>> $urandom_range(0, 14);
        cur_y = $signed(32'($urandom)) >>> $urandom_range(0, 14);
        case ($urandom_range(0, 3))
          0: begin goal_x = cur_x + $urandom_range(0, 1 << 22); goal_y = cur_y; end
          1: begin goal_x = cur_x; goal_y = cur_y + $urandom_range(0, 1 << 22); end
          2: begin goal_x = cur_x - $urandom_range(0, 1 << 22); goal_y = cur_y; end
          default: begin goal_x = cur_x; goal_y = cur_y - $urandom_range(0, 1 << 22); end
        endcase
        axis_hd = (goal_x > cur_x) ? 16'sd0 : (goal_y > cur_y) ? 16'sd16384 :
                  (goal_x < cur_x) ? -16'sd32768 : -16'sd16384;
      end else begin
        // step part of the way toward the goal, with some jitter
        cur_x = cur_x + ((goal_x - cur_x) >>> $urandom_range(1, 4)) + $signed($urandom_range(0, 400)) - 200;
        cur_y = cur_y + ((goal_y - cur_y) >>> $urandom_range(1, 4)) + $signed($urandom_range(0, 400)) - 200;
      end
      send_tick(cur_x, cur_y, axis_hd + 16'($signed($urandom_range(0, 8000)) - 4000),
                goal_x, goal_y, el, fresh);
    end
  endtask

  initial begin
    int sent;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed ticks at the register defaults
    send_tick(32'sd0, 32'sd0, 16'sd0, 32'sd0, 32'sd0, 20'd0, 1'b1);              // goal at pose
    send_tick(32'sd0, 32'sd0, 16'sd0, 32'sd65536, 32'sd0, 20'd1000, 1'b0);       // aligned drive
    send_tick(32'sd0, 32'sd0, 16'sd0, 32'sd1000, 32'sd0, 20'd1000, 1'b0);        // within tolerance
    send_tick(32'sd0, 32'sd0, 16'sd16384, 32'sd1 << 20, 32'sd0, 20'd5, 1'b0);    // not aligned
    send_tick(32'sd0, 32'sd0, -16'sd32768, 32'sd0, 32'sd1 << 22, 20'hFFFFF, 1'b0);
    send_tick(32'sd0, 32'sd0, 16'sd32767, -32'sd65536, 32'sd0, 20'd0, 1'b0);     // error near zero across the pi wrap
    send_tick(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'sd0, 32'h8000_0000, 32'h8000_0000,
              20'hFFFFF, 1'b0);                                                  // huge step, far goal
    send_tick(32'h8000_0000, 32'h8000_0000, 16'sd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              20'd7, 1'b1);
    send_tick(32'h8000_0000, 32'h7FFF_FFFF, -16'sd8192, 32'h7FFF_FFFF, 32'h8000_0000,
              20'd1, 1'b0);
    send_tick(32'sd5, -32'sd5, 16'sd0, -32'sd1 << 24, -32'sd3, 20'd999, 1'b0);

    // largest limits: distance overflow, widest alignment, no tolerance
    load_settings(32'h7FFF_FFFF, 32'h7FFF, 32'h7FFF, 32'h7FFF, 32'h0);
    send_tick(32'sd0, 32'sd0, 16'sd0, 32'sd0, 32'sd0, 20'd3, 1'b0);
    send_tick(32'h8000_0000, 32'sd0, 16'sd100, 32'h7FFF_FFFF, 32'sd0, 20'd3, 1'b0);
    send_tick(32'sd0, 32'sd0, 16'sd32767, 32'sd1 << 30, -32'sd1 << 30, 20'd3, 1'b1);
    // smallest limits: zero gain, zero alignment window, widest tolerance
    load_settings(32'h1, 32'h1, 32'h0, 32'h0, 32'h7FFF_FFFF);
    send_tick(32'sd0, 32'sd0, 16'sd0, 32'sd1 << 30, 32'sd0, 20'd3, 1'b0);
    send_tick(32'h8000_0000, 32'h8000_0000, 16'sd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 20'd3, 1'b0);
    load_settings(32'h1, 32'h1, 32'h7FFF, 32'h0, 32'h0);
    send_tick(32'sd0, 32'sd0, 16'sd1234, 32'sd12345, -32'sd54321, 20'd3, 1'b1);

    // random phases, each with fresh settings; the last returns to defaults
    sent = 0;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5)
        load_settings(32'd131072, 32'd4096, 32'd6144, 32'd3129, 32'd32768);
      else
        load_settings($urandom_range(1, 32'h7FFF_FFFF) >> $urandom_range(0, 20),
                      $urandom_range(1, 32767), $urandom_range(0, 32767),
                      $urandom_range(0, 32767), 32'($urandom_range(0, 32'h7FFF_FFFF)) >>
                      $urandom_range(8, 30));
      for (int k = 0; k < RANDOM_TICKS / 6; k++) begin
        if (ph == 1 && k == 40) begin
          // receiver holds off while ticks keep coming back to back
          hold_off_req = 1'b1;
          no_gaps = 1'b1;
        end
        if (ph == 1 && k == 50) no_gaps = 1'b0;
        if (ph == 2 && k == 60) begin
          // sender pause until every result is back
          in_valid = 1'b0;
          while (pending != 0) @(negedge clk);
        end
        random_tick((k % 12) == 0 || $urandom_range(0, 15) == 0);
        sent++;
      end
    end

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/gtg_pkg.sv
rtl/core/gtg_cordic.sv
rtl/core/gtg_divider.sv
rtl/core/go_to_goal_heading_controller_top.sv
verif/gtg_checker.sv
verif/tb_top.sv
